### design/fkdt_pkg.sv
// Package for the fingerprint-key double-tap filter.
// Holds payload types, code constants, phase enums and timing constants.
// Used by every module of the block; depends on nothing.
package fkdt_pkg;

  // Timing and limits
  localparam int BASE_CYCLES      = 8;
  localparam int CYCLE_TICKS      = 9;
  localparam int POWER_HOLD_TICKS = 60;
  localparam int WAIT_PERIOD_MAX  = 9;
  localparam int VIB_MAX          = 90;
  localparam int VIB_DEFAULT      = 20;
  localparam int WAIT_DEFAULT     = 2;

  // Results per request and result-queue depth
  localparam int MAX_RES = 3;
  localparam int QDEPTH  = 2;

  // Operation codes
  localparam logic [1:0] OP_KEY    = 2'd0;
  localparam logic [1:0] OP_SCREEN = 2'd1;
  localparam logic [1:0] OP_TICK   = 2'd2;

  // Filter modes
  localparam logic [1:0] MODE_OFF    = 2'd0;
  localparam logic [1:0] MODE_HOME   = 2'd1;
  localparam logic [1:0] MODE_DOUBLE = 2'd2;

  // Configuration register indexes
  localparam logic [1:0] CFG_MODE = 2'd0;
  localparam logic [1:0] CFG_WAIT = 2'd1;
  localparam logic [1:0] CFG_VIB  = 2'd2;

  // Result kinds
  localparam logic [1:0] K_DECIDE = 2'd0;
  localparam logic [1:0] K_HOME   = 2'd1;
  localparam logic [1:0] K_POWER  = 2'd2;
  localparam logic [1:0] K_VIB    = 2'd3;

  typedef enum logic [1:0] {
    WIN_COUNT,
    WIN_HOME,
    WIN_HOLD
  } win_phase_e;

  typedef enum logic [1:0] {
    PWR_IDLE,
    PWR_HOLD,
    PWR_LOCK
  } pwr_phase_e;

  typedef struct packed {
    logic [1:0] operation;
    logic       is_key_type;
    logic       key_pressed;
    logic       screen_level;
  } in_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [6:0] value;
    logic       last;
  } out_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [6:0] value;
  } res_t;

  // All results caused by one request
  typedef struct packed {
    logic [1:0]              count;
    res_t [MAX_RES-1:0]      res;
  } bundle_t;

  function automatic res_t make_res(logic [1:0] kind, logic [6:0] value);
    res_t r;
    r.kind  = kind;
    r.value = value;
    return r;
  endfunction

endpackage

### design/fkdt_front.sv
// Front end: configuration registers, gesture state and classification.
// Turns each accepted request that has results into a bundle for the queue.
// Depends on fkdt_pkg.
module fkdt_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [1:0]        cfg_index_i,
  input  logic [6:0]        cfg_data_i,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  fkdt_pkg::in_t     in_data_i,
  input  logic              full_i,
  output logic              push_o,
  output fkdt_pkg::bundle_t bundle_o
);

  logic [1:0] mode_q, mode_d;
  logic [3:0] wait_q, wait_d;
  logic [6:0] vib_q, vib_d;

  logic disp_on_q, disp_on_d;
  logic finger_down_q, finger_down_d;
  logic win_pending_q, win_pending_d;
  logic win_busy_q, win_busy_d;
  logic break_q, break_d;
  logic win_done_q, win_done_d;
  logic home_sent_q, home_sent_d;
  logic rel_owed_q, rel_owed_d;
  logic pwr_pending_q, pwr_pending_d;
  fkdt_pkg::win_phase_e win_phase_q, win_phase_d;
  fkdt_pkg::pwr_phase_e pwr_phase_q, pwr_phase_d;
  logic [7:0] win_ticks_q, win_ticks_d;
  logic [6:0] pwr_ticks_q, pwr_ticks_d;

  logic acc, op_key, op_scr, op_tick;
  logic key_pass, m1_on, m2, m2_press, m2_rel_on, dbl_tap, m2_open, consume;
  logic w_start, w_count, w_break, w_home, w_rel, w_free;
  logic p_press, p_rel, p_done;
  logic [7:0] limit, win_inc;
  logic [6:0] pwr_inc;
  logic [1:0] n;
  fkdt_pkg::res_t [fkdt_pkg::MAX_RES-1:0] res;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = full_i;
  assign acc         = in_valid_i && !full_i;

  // Decode configuration writes; a bad mode turns the filter off, other bad values fall back to defaults
  always_comb begin
    mode_d = mode_q;
    wait_d = wait_q;
    vib_d  = vib_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        fkdt_pkg::CFG_MODE:
          mode_d = (cfg_data_i > 7'(fkdt_pkg::MODE_DOUBLE)) ? fkdt_pkg::MODE_OFF
                                                             : cfg_data_i[1:0];
        fkdt_pkg::CFG_WAIT:
          wait_d = (cfg_data_i > 7'(fkdt_pkg::WAIT_PERIOD_MAX)) ?
                   4'(fkdt_pkg::WAIT_DEFAULT) : cfg_data_i[3:0];
        fkdt_pkg::CFG_VIB:
          vib_d = (cfg_data_i > 7'(fkdt_pkg::VIB_MAX)) ? 7'(fkdt_pkg::VIB_DEFAULT)
                                                        : cfg_data_i;
        default: ;
      endcase
    end
  end

  // Classify the request
  always_comb begin
    op_key  = acc && (in_data_i.operation == fkdt_pkg::OP_KEY);
    op_scr  = acc && (in_data_i.operation == fkdt_pkg::OP_SCREEN);
    op_tick = acc && (in_data_i.operation == fkdt_pkg::OP_TICK);

    key_pass   = (mode_q == fkdt_pkg::MODE_OFF) || !in_data_i.is_key_type;
    m1_on      = op_key && !key_pass && (mode_q == fkdt_pkg::MODE_HOME) && disp_on_q;
    m2         = op_key && !key_pass && (mode_q == fkdt_pkg::MODE_DOUBLE);
    m2_press   = m2 && in_data_i.key_pressed && disp_on_q;
    m2_rel_on  = m2 && !in_data_i.key_pressed && finger_down_q && disp_on_q;
    dbl_tap    = m2_press && win_busy_q && !win_done_q;
    m2_open    = m2_press && !win_busy_q;
    consume    = m1_on || m2_press || m2_rel_on;

    limit   = 8'((fkdt_pkg::BASE_CYCLES + int'(wait_q)) * fkdt_pkg::CYCLE_TICKS);
    win_inc = win_ticks_q + 8'd1;
    w_start = op_tick && !win_busy_q && win_pending_q;
    w_count = op_tick && win_busy_q && (win_phase_q == fkdt_pkg::WIN_COUNT) && !break_q;
    w_break = op_tick && win_busy_q && (win_phase_q == fkdt_pkg::WIN_COUNT) && break_q;
    w_home  = w_count && ((win_inc >= limit) || (win_inc == 8'd0));
    w_rel   = op_tick && win_busy_q && (win_phase_q == fkdt_pkg::WIN_HOME) && rel_owed_q;
    w_free  = op_tick && win_busy_q &&
              (((win_phase_q == fkdt_pkg::WIN_HOME) && !rel_owed_q) ||
               (win_phase_q == fkdt_pkg::WIN_HOLD));

    pwr_inc = pwr_ticks_q + 7'd1;
    p_press = op_tick && (pwr_phase_q == fkdt_pkg::PWR_IDLE) && pwr_pending_q;
    p_rel   = op_tick && (pwr_phase_q == fkdt_pkg::PWR_HOLD) &&
              (pwr_inc >= 7'(fkdt_pkg::POWER_HOLD_TICKS));
    p_done  = op_tick && (pwr_phase_q == fkdt_pkg::PWR_LOCK) &&
              (pwr_inc >= 7'(fkdt_pkg::POWER_HOLD_TICKS / 2));
  end

  // Next state
  always_comb begin
    disp_on_d     = op_scr ? in_data_i.screen_level : disp_on_q;
    finger_down_d = finger_down_q;
    home_sent_d   = home_sent_q;
    break_d       = break_q;
    win_pending_d = win_pending_q;
    win_busy_d    = win_busy_q;
    win_done_d    = win_done_q;
    win_phase_d   = win_phase_q;
    win_ticks_d   = win_ticks_q;
    rel_owed_d    = rel_owed_q;
    pwr_pending_d = pwr_pending_q;
    pwr_phase_d   = pwr_phase_q;
    pwr_ticks_d   = pwr_ticks_q;

    // key presses and releases
    if (m2_press) begin
      finger_down_d = 1'b1;
      home_sent_d   = 1'b0;
      break_d       = 1'b1;
    end
    if (m2_open) win_pending_d = 1'b1;
    if (dbl_tap) begin
      pwr_pending_d = 1'b1;
      rel_owed_d    = 1'b0;
    end
    if (m2_rel_on) begin
      finger_down_d = 1'b0;
      if (!home_sent_q) rel_owed_d = 1'b1;
    end

    // window sequence
    if (w_start) begin
      win_pending_d = 1'b0;
      win_busy_d    = 1'b1;
      break_d       = 1'b0;
      win_done_d    = 1'b0;
      win_phase_d   = fkdt_pkg::WIN_COUNT;
      win_ticks_d   = 8'd0;
    end
    if (w_break) begin
      win_done_d = 1'b1;
      win_busy_d = 1'b0;
    end
    if (w_count) win_ticks_d = win_inc;
    if (w_home) begin
      win_done_d  = 1'b1;
      home_sent_d = 1'b1;
      win_phase_d = fkdt_pkg::WIN_HOME;
    end
    if (w_rel) begin
      rel_owed_d  = 1'b0;
      win_phase_d = fkdt_pkg::WIN_HOLD;
    end
    if (w_free) begin
      win_phase_d = fkdt_pkg::WIN_COUNT;
      win_busy_d  = 1'b0;
    end

    // power sequence
    if (op_tick) begin
      unique case (pwr_phase_q)
        fkdt_pkg::PWR_IDLE: begin
          if (p_press) begin
            pwr_pending_d = 1'b0;
            pwr_phase_d   = fkdt_pkg::PWR_HOLD;
            pwr_ticks_d   = 7'd0;
          end
        end
        fkdt_pkg::PWR_HOLD: begin
          pwr_ticks_d = pwr_inc;
          if (p_rel) begin
            pwr_phase_d = fkdt_pkg::PWR_LOCK;
            pwr_ticks_d = 7'd0;
          end
        end
        default: begin
          pwr_ticks_d = pwr_inc;
          if (p_done) begin
            rel_owed_d  = 1'b0;
            pwr_phase_d = fkdt_pkg::PWR_IDLE;
            pwr_ticks_d = 7'd0;
          end
        end
      endcase
    end
  end

  // Build the result bundle: side events first, decision last for a key request
  always_comb begin
    n   = 2'd0;
    res = '0;
    if (op_key) begin
      if (m1_on && in_data_i.key_pressed) begin
        res[0] = fkdt_pkg::make_res(fkdt_pkg::K_VIB, vib_q);
        res[1] = fkdt_pkg::make_res(fkdt_pkg::K_HOME, 7'd1);
        n      = 2'd2;
      end else if (m1_on) begin
        res[0] = fkdt_pkg::make_res(fkdt_pkg::K_HOME, 7'd0);
        n      = 2'd1;
      end else if (dbl_tap) begin
        res[0] = fkdt_pkg::make_res(fkdt_pkg::K_VIB, vib_q);
        n      = 2'd1;
      end else if (m2_rel_on && home_sent_q) begin
        res[0] = fkdt_pkg::make_res(fkdt_pkg::K_HOME, 7'd0);
        n      = 2'd1;
      end
      res[n] = fkdt_pkg::make_res(fkdt_pkg::K_DECIDE, {6'd0, consume});
      n      = n + 2'd1;
    end else if (op_tick) begin
      if (w_start) begin
        res[0] = fkdt_pkg::make_res(fkdt_pkg::K_VIB, vib_q);
        n      = 2'd1;
      end else if (w_home) begin
        res[0] = fkdt_pkg::make_res(fkdt_pkg::K_HOME, 7'd1);
        n      = 2'd1;
      end else if (w_rel) begin
        res[0] = fkdt_pkg::make_res(fkdt_pkg::K_HOME, 7'd0);
        n      = 2'd1;
      end
      if (p_press) begin
        res[n] = fkdt_pkg::make_res(fkdt_pkg::K_POWER, 7'd1);
        n      = n + 2'd1;
      end else if (p_rel) begin
        res[n] = fkdt_pkg::make_res(fkdt_pkg::K_POWER, 7'd0);
        n      = n + 2'd1;
      end
    end
    push_o         = n != 2'd0;
    bundle_o.count = n;
    bundle_o.res   = res;
  end

  // Hold configuration and gesture state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q        <= fkdt_pkg::MODE_DOUBLE;
      wait_q        <= 4'(fkdt_pkg::WAIT_DEFAULT);
      vib_q         <= 7'(fkdt_pkg::VIB_DEFAULT);
      disp_on_q     <= 1'b1;
      finger_down_q <= 1'b0;
      win_pending_q <= 1'b0;
      win_busy_q    <= 1'b0;
      break_q       <= 1'b1;
      win_done_q    <= 1'b0;
      home_sent_q   <= 1'b0;
      rel_owed_q    <= 1'b0;
      pwr_pending_q <= 1'b0;
      win_phase_q   <= fkdt_pkg::WIN_COUNT;
      pwr_phase_q   <= fkdt_pkg::PWR_IDLE;
      win_ticks_q   <= 8'd0;
      pwr_ticks_q   <= 7'd0;
    end else begin
      mode_q        <= mode_d;
      wait_q        <= wait_d;
      vib_q         <= vib_d;
      disp_on_q     <= disp_on_d;
      finger_down_q <= finger_down_d;
      win_pending_q <= win_pending_d;
      win_busy_q    <= win_busy_d;
      break_q       <= break_d;
      win_done_q    <= win_done_d;
      home_sent_q   <= home_sent_d;
      rel_owed_q    <= rel_owed_d;
      pwr_pending_q <= pwr_pending_d;
      win_phase_q   <= win_phase_d;
      pwr_phase_q   <= pwr_phase_d;
      win_ticks_q   <= win_ticks_d;
      pwr_ticks_q   <= pwr_ticks_d;
    end
  end

endmodule

### design/fkdt_queue.sv
// Short queue of result bundles between the front and back ends.
// Register based, one push and one pop per cycle. Depends on fkdt_pkg.
module fkdt_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  fkdt_pkg::bundle_t wdata_i,
  output logic              full_o,
  input  logic              pop_i,
  output logic              empty_o,
  output fkdt_pkg::bundle_t rdata_o
);

  localparam int PtrW = (fkdt_pkg::QDEPTH > 1) ? $clog2(fkdt_pkg::QDEPTH) : 1;
  localparam int CntW = $clog2(fkdt_pkg::QDEPTH + 1);

  fkdt_pkg::bundle_t mem_q [fkdt_pkg::QDEPTH];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  assign full_o  = cnt_q == CntW'(fkdt_pkg::QDEPTH);
  assign empty_o = cnt_q == '0;
  assign rdata_o = mem_q[rd_ptr_q];

  // Advance pointers and fill count
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(fkdt_pkg::QDEPTH - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(fkdt_pkg::QDEPTH - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (push_i && !pop_i) cnt_d = cnt_q + CntW'(1);
    else if (!push_i && pop_i) cnt_d = cnt_q - CntW'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Store bundles
  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= wdata_i;
  end

`ifndef SYNTH
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o) else $error("queue push while full");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o) else $error("queue pop while empty");
  a_nonempty_bundle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> (wdata_i.count != 2'd0)) else $error("empty bundle pushed");
`endif

endmodule

### design/fkdt_back.sv
// Back end: hands out the results of the head bundle one per cycle while out_stall_i is low.
// Marks the final result of each request. Depends on fkdt_pkg.
module fkdt_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              empty_i,
  input  fkdt_pkg::bundle_t bundle_i,
  output logic              pop_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output fkdt_pkg::out_t    out_data_o
);

  logic [1:0] idx_q, idx_d;
  logic       last, advance;

  assign out_valid_o      = !empty_i;
  assign last             = idx_q == (bundle_i.count - 2'd1);
  assign advance          = out_valid_o && !out_stall_i;
  assign pop_o            = advance && last;
  assign out_data_o.kind  = bundle_i.res[idx_q].kind;
  assign out_data_o.value = bundle_i.res[idx_q].value;
  assign out_data_o.last  = last;

  // Step through the bundle, wrap on its last result
  always_comb begin
    idx_d = idx_q;
    if (advance) idx_d = last ? 2'd0 : idx_q + 2'd1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= 2'd0;
    end else begin
      idx_q <= idx_d;
    end
  end

`ifndef SYNTH
  a_idx_in_bundle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (idx_q < bundle_i.count)) else $error("result index past bundle");
  a_idx_rest: assert property (@(posedge clk_i) disable iff (!rst_ni)
    empty_i |-> (idx_q == 2'd0)) else $error("result index not reset on empty queue");
`endif

endmodule

### design/fingerprint_key_double_tap_filter_core.sv
// Top level of the fingerprint-key double-tap filter.
// Connects fkdt_front, fkdt_queue and fkdt_back; depends on fkdt_pkg.
//
//  channel | direction | handshake                | payload
//  --------+-----------+--------------------------+----------------------------
//  cfg     | in        | cfg_valid_i / cfg_ready_o | cfg_index_i, cfg_data_i
//  in      | in        | in_valid_i / in_stall_o   | in_data_i (operation, flags)
//  out     | out       | out_valid_o / out_stall_i | out_data_o (kind, value, last)
//
// A request is classified in the cycle it is accepted; one request per cycle while in_stall_o is low.
// Its results (up to three) are queued and leave one per cycle while out_stall_i is low.
// A two-entry bundle queue sits between the front and back ends; in_stall_o
// rises only while that queue is full. Configuration writes are registered.
// Reset is asynchronous; no clearing pass is needed.
module fingerprint_key_double_tap_filter_core (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cfg_valid_i,
  output logic           cfg_ready_o,
  input  logic [1:0]     cfg_index_i,
  input  logic [6:0]     cfg_data_i,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  fkdt_pkg::in_t  in_data_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output fkdt_pkg::out_t out_data_o
);

  logic              push, pop, full, empty;
  fkdt_pkg::bundle_t wbundle, rbundle;

  fkdt_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .full_i      (full),
    .push_o      (push),
    .bundle_o    (wbundle)
  );

  fkdt_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (wbundle),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .rdata_o (rbundle)
  );

  fkdt_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .empty_i     (empty),
    .bundle_i    (rbundle),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

### test/fkdt_gesture_checker.sv
`timescale 1ns / 1ps
// Checker for the fingerprint-key double-tap filter: watches the cfg, in and out channels,
// predicts every key, screen and tick request and compares each result field by field.
// Depends on fkdt_pkg for the payload types, codes and timing constants.
module fkdt_gesture_checker (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cfg_valid_i,
  input  logic           cfg_ready_i,
  input  logic [1:0]     cfg_index_i,
  input  logic [6:0]     cfg_data_i,
  input  logic           in_valid_i,
  input  logic           in_stall_i,
  input  fkdt_pkg::in_t  in_data_i,
  input  logic           out_valid_i,
  input  logic           out_stall_i,
  input  fkdt_pkg::out_t out_data_i,
  output int             fail_count_o,
  output int             pending_o
);

  // Register copies
  logic [1:0] cfg_mode;
  logic [3:0] cfg_wait_cycles;
  logic [6:0] cfg_vib;

  // Gesture state
  logic                 disp_on, finger_down, off_while_pressed;
  logic                 win_pending, win_busy, brk_req, win_done;
  logic                 home_sent, release_owed, power_pending;
  fkdt_pkg::win_phase_e win_ph;
  logic [7:0]           win_ticks;
  fkdt_pkg::pwr_phase_e pwr_ph;
  logic [6:0]           pwr_ticks;

  // Events of the current request, then every event still owed by the block
  fkdt_pkg::out_t step_events[$];
  fkdt_pkg::out_t gesture_q[$];

  task automatic add_event(input logic [1:0] kind, input logic [6:0] value);
    fkdt_pkg::out_t e;
    e.kind  = kind;
    e.value = value;
    e.last  = 1'b0;
    step_events.push_back(e);
  endtask

  task automatic reset_gesture_state();
    cfg_mode          = fkdt_pkg::MODE_DOUBLE;
    cfg_wait_cycles   = 4'(fkdt_pkg::WAIT_DEFAULT);
    cfg_vib           = 7'(fkdt_pkg::VIB_DEFAULT);
    disp_on           = 1'b1;
    finger_down       = 1'b0;
    off_while_pressed = 1'b0;
    win_pending       = 1'b0;
    win_busy          = 1'b0;
    win_ph            = fkdt_pkg::WIN_COUNT;
    win_ticks         = '0;
    brk_req           = 1'b1;
    win_done          = 1'b0;
    home_sent         = 1'b0;
    release_owed      = 1'b0;
    power_pending     = 1'b0;
    pwr_ph            = fkdt_pkg::PWR_IDLE;
    pwr_ticks         = '0;
    step_events.delete();
    gesture_q.delete();
  endtask

  // A bad mode turns the filter off; other out-of-range writes fall back to defaults
  task automatic apply_register_write(input logic [1:0] idx, input logic [6:0] data);
    case (idx)
      fkdt_pkg::CFG_MODE:
        cfg_mode = (data > fkdt_pkg::MODE_DOUBLE) ? fkdt_pkg::MODE_OFF : data[1:0];
      fkdt_pkg::CFG_WAIT:
        cfg_wait_cycles = (data > fkdt_pkg::WAIT_PERIOD_MAX) ?
                          4'(fkdt_pkg::WAIT_DEFAULT) : data[3:0];
      fkdt_pkg::CFG_VIB:
        cfg_vib = (data > fkdt_pkg::VIB_MAX) ? 7'(fkdt_pkg::VIB_DEFAULT) : data;
      default: ;
    endcase
  endtask

  // Advance the double-tap window by one tick
  task automatic tick_window();
    int limit;
    limit = (fkdt_pkg::BASE_CYCLES + int'(cfg_wait_cycles)) * fkdt_pkg::CYCLE_TICKS;
    if (!win_busy) begin
      if (win_pending) begin
        win_pending = 1'b0;
        win_busy    = 1'b1;
        brk_req     = 1'b0;
        win_done    = 1'b0;
        win_ph      = fkdt_pkg::WIN_COUNT;
        win_ticks   = '0;
        add_event(fkdt_pkg::K_VIB, cfg_vib);
      end
    end else if (win_ph == fkdt_pkg::WIN_COUNT) begin
      if (brk_req) begin
        // second press came: close the window quietly
        win_done = 1'b1;
        win_busy = 1'b0;
      end else begin
        win_ticks = win_ticks + 8'd1;
        if (int'(win_ticks) >= limit || win_ticks == 8'd0) begin
          win_done  = 1'b1;
          home_sent = 1'b1;
          win_ph    = fkdt_pkg::WIN_HOME;
          add_event(fkdt_pkg::K_HOME, 7'd1);
        end
      end
    end else if (win_ph == fkdt_pkg::WIN_HOME) begin
      if (release_owed) begin
        release_owed = 1'b0;
        win_ph       = fkdt_pkg::WIN_HOLD;
        add_event(fkdt_pkg::K_HOME, 7'd0);
      end else begin
        win_ph   = fkdt_pkg::WIN_COUNT;
        win_busy = 1'b0;
      end
    end else begin
      win_ph   = fkdt_pkg::WIN_COUNT;
      win_busy = 1'b0;
    end
  endtask

  // Advance the power press, hold and lockout sequence by one tick
  task automatic tick_power();
    if (pwr_ph == fkdt_pkg::PWR_IDLE) begin
      if (power_pending) begin
        power_pending = 1'b0;
        pwr_ph        = fkdt_pkg::PWR_HOLD;
        pwr_ticks     = '0;
        add_event(fkdt_pkg::K_POWER, 7'd1);
      end
    end else if (pwr_ph == fkdt_pkg::PWR_HOLD) begin
      pwr_ticks = pwr_ticks + 7'd1;
      if (int'(pwr_ticks) >= fkdt_pkg::POWER_HOLD_TICKS) begin
        pwr_ph    = fkdt_pkg::PWR_LOCK;
        pwr_ticks = '0;
        add_event(fkdt_pkg::K_POWER, 7'd0);
      end
    end else begin
      pwr_ticks = pwr_ticks + 7'd1;
      if (int'(pwr_ticks) >= fkdt_pkg::POWER_HOLD_TICKS / 2) begin
        release_owed = 1'b0;
        pwr_ph       = fkdt_pkg::PWR_IDLE;
        pwr_ticks    = '0;
      end
    end
  endtask

  // Press with the screen on in double-tap mode
  task automatic press_trigger();
    home_sent = 1'b0;
    brk_req   = 1'b1;
    if (win_busy) begin
      if (!win_done) begin
        off_while_pressed = finger_down;
        add_event(fkdt_pkg::K_VIB, cfg_vib);
        power_pending = 1'b1;
        release_owed  = 1'b0;
      end
    end else begin
      win_pending = 1'b1;
    end
  endtask

  // Side events first, the consume or pass decision last
  task automatic key_event(input logic key_type, input logic pressed);
    logic consume;
    consume = 1'b0;
    if (key_type && cfg_mode == fkdt_pkg::MODE_DOUBLE) begin
      if (pressed) begin
        if (disp_on) begin
          finger_down = 1'b1;
          press_trigger();
          consume = 1'b1;
        end
      end else if (finger_down) begin
        if (!disp_on) begin
          off_while_pressed = 1'b0;
        end else begin
          finger_down = 1'b0;
          if (home_sent) add_event(fkdt_pkg::K_HOME, 7'd0);
          else release_owed = 1'b1;
          consume = 1'b1;
        end
      end
    end else if (key_type && cfg_mode == fkdt_pkg::MODE_HOME) begin
      if (disp_on) begin
        if (pressed) begin
          add_event(fkdt_pkg::K_VIB, cfg_vib);
          add_event(fkdt_pkg::K_HOME, 7'd1);
        end else begin
          add_event(fkdt_pkg::K_HOME, 7'd0);
        end
        consume = 1'b1;
      end
    end
    add_event(fkdt_pkg::K_DECIDE, {6'd0, consume});
  endtask

  // Work out every result of one accepted request
  task automatic apply_request(input fkdt_pkg::in_t req);
    step_events.delete();
    case (req.operation)
      fkdt_pkg::OP_KEY:    key_event(req.is_key_type, req.key_pressed);
      fkdt_pkg::OP_SCREEN: disp_on = req.screen_level;
      fkdt_pkg::OP_TICK: begin
        tick_window();
        tick_power();
      end
      default: ;
    endcase
    if (step_events.size() > 0) step_events[step_events.size() - 1].last = 1'b1;
    foreach (step_events[i]) gesture_q.push_back(step_events[i]);
  endtask

  // Hold the oldest owed event against what the block sent
  task automatic compare_result(input fkdt_pkg::out_t got);
    fkdt_pkg::out_t want;
    if (gesture_q.size() == 0) begin
      $error("result with no request behind it: kind %0d value %0d last %0d",
             got.kind, got.value, got.last);
      fail_count_o++;
    end else begin
      want = gesture_q.pop_front();
      if (got.kind !== want.kind) begin
        $error("kind mismatch: expected %0d, actual %0d", want.kind, got.kind);
        fail_count_o++;
      end
      if (got.value !== want.value) begin
        $error("value mismatch: expected %0d, actual %0d", want.value, got.value);
        fail_count_o++;
      end
      if (got.last !== want.last) begin
        $error("last mismatch: expected %0d, actual %0d", want.last, got.last);
        fail_count_o++;
      end
    end
  endtask

  // Compare results before predicting the request of the same edge
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      reset_gesture_state();
      fail_count_o = 0;
      pending_o    = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) apply_register_write(cfg_index_i, cfg_data_i);
      if (out_valid_i && !out_stall_i) compare_result(out_data_i);
      if (in_valid_i && !in_stall_i) apply_request(in_data_i);
      pending_o = gesture_q.size();
    end
  end

endmodule

### test/tb.sv
`timescale 1ns / 1ps
// Top of the fingerprint-key double-tap filter testbench: clock, reset, request stimulus,
// random idling on both channels and the verdict. Depends on fkdt_pkg, the core and
// fkdt_gesture_checker.
module tb;

  // Codes the package leaves unnamed
  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam logic [1:0] CFG_NONE  = 2'd3;

  localparam int SETTLE_CYCLES = 10;
  localparam int LONG_HOLD     = 60;
  localparam int DRAIN_LIMIT   = 5000;

  logic clk_i, rst_ni;
  logic cfg_valid_i, cfg_ready_o;
  logic [1:0] cfg_index_i;
  logic [6:0] cfg_data_i;
  logic in_valid_i, in_stall_o;
  fkdt_pkg::in_t  in_data_i;
  logic out_valid_o, out_stall_i;
  fkdt_pkg::out_t out_data_o;

  int fail_count, pending;
  int send_idle_pct, recv_idle_pct;
  int sent_count;
  logic hold_req;

  fingerprint_key_double_tap_filter_core u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  fkdt_gesture_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_i  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_stall_i   (in_stall_o),
    .in_data_i    (in_data_i),
    .out_valid_i  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_data_i   (out_data_o),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // Stall the result channel at random; hold off for a long stretch on request
  initial begin : receiver
    int hold_left;
    logic hold_ack;
    hold_left   = 0;
    hold_ack    = 1'b0;
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_left > 0) begin
        hold_left--;
      end else if (hold_req != hold_ack) begin
        hold_ack  = hold_req;
        hold_left = LONG_HOLD;
      end
      out_stall_i <= (hold_left > 0) ||
                     (recv_idle_pct > 0 && $urandom_range(1, 100) <= recv_idle_pct);
    end
  end

  function automatic fkdt_pkg::in_t mk_req(logic [1:0] op, logic key_type, logic pressed,
                                           logic level);
    fkdt_pkg::in_t r;
    r.operation    = op;
    r.is_key_type  = key_type;
    r.key_pressed  = pressed;
    r.screen_level = level;
    return r;
  endfunction

  // Offer one request, idling first at random; leave valid high after acceptance
  task automatic push_request(input fkdt_pkg::in_t req);
    while (send_idle_pct > 0 && $urandom_range(1, 100) <= send_idle_pct) begin
      in_valid_i = 1'b0;
      in_data_i  = 5'($urandom_range(0, 31));
      @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    in_data_i  = req;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sent_count++;
    @(negedge clk_i);
  endtask

  // Drop valid, wait for every owed result, then let the block go quiet
  task automatic settle();
    in_valid_i = 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [6:0] data);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  // Press and release gestures separated by short gaps or whole windows of ticks,
  // with blanking and random noise mixed in
  task automatic run_gestures(input int n_items, input int wait_cycles);
    int start;
    int stretch;
    logic finger;
    fkdt_pkg::in_t req;
    start  = sent_count;
    finger = 1'b0;
    while (sent_count - start < n_items) begin
      if ($urandom_range(0, 5) != 0) finger = !finger;
      push_request(mk_req(fkdt_pkg::OP_KEY, $urandom_range(0, 9) != 0, finger,
                          1'($urandom_range(0, 1))));
      if ($urandom_range(0, 3) == 0)
        stretch = (fkdt_pkg::BASE_CYCLES + wait_cycles) * fkdt_pkg::CYCLE_TICKS +
                  int'($urandom_range(1, 6));
      else
        stretch = int'($urandom_range(1, 12));
      repeat (stretch) begin
        case ($urandom_range(0, 19))
          0: req = 5'($urandom_range(0, 31));
          1: req = mk_req(fkdt_pkg::OP_SCREEN, 1'($urandom_range(0, 1)),
                          1'($urandom_range(0, 1)), $urandom_range(0, 3) != 0);
          default: req = mk_req(fkdt_pkg::OP_TICK, 1'($urandom_range(0, 1)),
                                1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        endcase
        push_request(req);
      end
    end
  endtask

  initial begin : stimulus
    int drain;
    rst_ni        = 1'b0;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = fkdt_pkg::CFG_MODE;
    cfg_data_i    = '0;
    in_valid_i    = 1'b0;
    in_data_i     = '0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    sent_count    = 0;
    hold_req      = 1'b0;
    repeat (7) @(negedge clk_i);
    rst_ni = 1'b1;

    // Double-tap mode at reset values: pass cases, blanking, then a double tap
    push_request(mk_req(OP_UNUSED, 1'b1, 1'b1, 1'b1));            // ignored operation
    push_request(mk_req(fkdt_pkg::OP_KEY, 1'b0, 1'b1, 1'b0));     // not a key type
    push_request(mk_req(fkdt_pkg::OP_KEY, 1'b1, 1'b0, 1'b1));     // release with no press
    push_request(mk_req(fkdt_pkg::OP_SCREEN, 1'b0, 1'b0, 1'b0));
    push_request(mk_req(fkdt_pkg::OP_KEY, 1'b1, 1'b1, 1'b0));     // press while blank
    push_request(mk_req(fkdt_pkg::OP_SCREEN, 1'b1, 1'b1, 1'b1));
    push_request(mk_req(fkdt_pkg::OP_KEY, 1'b1, 1'b1, 1'b0));     // first press
    push_request(mk_req(fkdt_pkg::OP_SCREEN, 1'b0, 1'b0, 1'b0));
    push_request(mk_req(fkdt_pkg::OP_KEY, 1'b1, 1'b0, 1'b1));     // release while blank
    push_request(mk_req(fkdt_pkg::OP_SCREEN, 1'b0, 1'b0, 1'b1));
    push_request(mk_req(fkdt_pkg::OP_TICK, 1'b0, 1'b0, 1'b0));    // window opens
    push_request(mk_req(fkdt_pkg::OP_KEY, 1'b1, 1'b1, 1'b1));     // second press in window
    push_request(mk_req(fkdt_pkg::OP_KEY, 1'b1, 1'b0, 1'b0));     // release owed
    push_request(mk_req(fkdt_pkg::OP_TICK, 1'b1, 1'b1, 1'b1));    // window breaks, power press
    push_request(mk_req(fkdt_pkg::OP_TICK, 1'b0, 1'b0, 1'b0));
    settle();

    // Plain home-key mode
    write_reg(fkdt_pkg::CFG_MODE, {5'd0, fkdt_pkg::MODE_HOME});
    push_request(mk_req(fkdt_pkg::OP_KEY, 1'b1, 1'b1, 1'b0));
    push_request(mk_req(fkdt_pkg::OP_KEY, 1'b1, 1'b0, 1'b0));
    push_request(mk_req(fkdt_pkg::OP_SCREEN, 1'b0, 1'b0, 1'b0));
    push_request(mk_req(fkdt_pkg::OP_KEY, 1'b1, 1'b1, 1'b0));
    push_request(mk_req(fkdt_pkg::OP_SCREEN, 1'b0, 1'b0, 1'b1));
    settle();

    // Out-of-range writes turn the filter off or fall back to defaults; index with no register is dropped
    write_reg(fkdt_pkg::CFG_MODE, 7'd3);
    write_reg(fkdt_pkg::CFG_WAIT, 7'd127);
    write_reg(fkdt_pkg::CFG_VIB, 7'd127);
    write_reg(CFG_NONE, 7'h55);
    push_request(mk_req(fkdt_pkg::OP_KEY, 1'b1, 1'b1, 1'b1));     // filter off
    settle();

    // Shortest window, strongest pulse; sender idles less than the receiver
    write_reg(fkdt_pkg::CFG_MODE, {5'd0, fkdt_pkg::MODE_DOUBLE});
    write_reg(fkdt_pkg::CFG_WAIT, 7'd0);
    write_reg(fkdt_pkg::CFG_VIB, 7'd90);
    send_idle_pct = 30;
    recv_idle_pct <= 51;
    run_gestures(110, 0);
    settle();

    // Longest window, zero strength; idling the other way round
    write_reg(fkdt_pkg::CFG_MODE, {5'd0, fkdt_pkg::MODE_HOME});
    write_reg(fkdt_pkg::CFG_WAIT, 7'd9);
    write_reg(fkdt_pkg::CFG_VIB, 7'd0);
    send_idle_pct = 51;
    recv_idle_pct <= 30;
    run_gestures(40, 9);
    settle();
    write_reg(fkdt_pkg::CFG_MODE, {5'd0, fkdt_pkg::MODE_DOUBLE});
    run_gestures(110, 9);
    settle();

    // No idling: long result hold-off to back up the input, then a full pause
    write_reg(fkdt_pkg::CFG_WAIT, 7'd3);
    write_reg(fkdt_pkg::CFG_VIB, 7'd45);
    send_idle_pct = 0;
    recv_idle_pct <= 0;
    hold_req <= 1'b1;
    repeat (12) push_request(mk_req(fkdt_pkg::OP_KEY, 1'b0, 1'($urandom_range(0, 1)),
                                    1'($urandom_range(0, 1))));
    settle();
    run_gestures(80, 3);
    settle();
    write_reg(fkdt_pkg::CFG_MODE, {5'd0, fkdt_pkg::MODE_OFF});
    run_gestures(20, 3);

    // Wait out every owed result, then the block's latency
    in_valid_i = 1'b0;
    drain = 0;
    while (pending != 0 && drain < DRAIN_LIMIT) begin
      @(negedge clk_i);
      drain++;
    end
    repeat (SETTLE_CYCLES) @(negedge clk_i);
    if (pending != 0) $error("%0d results never arrived", pending);
    if (fail_count == 0 && pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin : watchdog
    #2_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
